@@ rtl/ubsr_pkg.sv @@
`default_nettype none

package ubsr_pkg;

    // Width of each button hold counter (11..32)
    localparam int HOLD_WIDTH = 16;

    // Field widths
    localparam int STEP_WIDTH  = 7;
    localparam int LEVEL_WIDTH = 8;
    localparam int RPT_WIDTH   = 10;
    localparam int LONG_WIDTH  = 16;

    // Compare width for hold count against the thresholds
    localparam int CMP_WIDTH = (HOLD_WIDTH > LONG_WIDTH) ? HOLD_WIDTH : LONG_WIDTH;

    // Configuration port
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 16;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_STEP_SIZE        = 2'd0,
        REG_SETPOINT_MAX     = 2'd1,
        REG_REPEAT_AFTER     = 2'd2,
        REG_LONG_PRESS_AFTER = 2'd3
    } cfg_index_t;

    // Register reset values
    localparam logic [STEP_WIDTH-1:0]  STEP_SIZE_RST        = 7'd4;
    localparam logic [LEVEL_WIDTH-1:0] SETPOINT_MAX_RST     = 8'd254;
    localparam logic [RPT_WIDTH-1:0]   REPEAT_AFTER_RST     = 10'd13;
    localparam logic [LONG_WIDTH-1:0]  LONG_PRESS_AFTER_RST = 16'd500;

    typedef struct packed {
        logic [STEP_WIDTH-1:0]  step_size;
        logic [LEVEL_WIDTH-1:0] setpoint_max;
        logic [RPT_WIDTH-1:0]   repeat_after;
        logic [LONG_WIDTH-1:0]  long_press_after;
    } cfg_t;

    // One tick's result
    typedef struct packed {
        logic [LEVEL_WIDTH-1:0] setpoint_value;
        logic                   updated;
        logic                   calibrate_request;
    } result_t;

endpackage

`default_nettype wire

@@ rtl/ubsr_cfg_regs.sv @@
`default_nettype none

module ubsr_cfg_regs
    import ubsr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       wr_en,
    input  wire logic [CFG_INDEX_WIDTH-1:0] wr_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  wr_data,
    output cfg_t                            cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write index
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_index_t'(wr_index))
                REG_STEP_SIZE:        cfg_next.step_size        = wr_data[STEP_WIDTH-1:0];
                REG_SETPOINT_MAX:     cfg_next.setpoint_max     = wr_data[LEVEL_WIDTH-1:0];
                REG_REPEAT_AFTER:     cfg_next.repeat_after     = wr_data[RPT_WIDTH-1:0];
                REG_LONG_PRESS_AFTER: cfg_next.long_press_after = wr_data[LONG_WIDTH-1:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.step_size        <= STEP_SIZE_RST;
            cfg_reg.setpoint_max     <= SETPOINT_MAX_RST;
            cfg_reg.repeat_after     <= REPEAT_AFTER_RST;
            cfg_reg.long_press_after <= LONG_PRESS_AFTER_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ rtl/ubsr_hold_counter.sv @@
`default_nettype none

module ubsr_hold_counter
    import ubsr_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  advance,
    input  wire logic                  pressed,
    output logic      [HOLD_WIDTH-1:0] hold
);

    logic [HOLD_WIDTH-1:0] hold_reg;
    logic [HOLD_WIDTH-1:0] hold_next;

    // Count consecutive pressed ticks, saturate at all ones, clear on release
    always_comb
    begin
        if (!pressed)
            hold_next = '0;
        else if (&hold_reg)
            hold_next = hold_reg;
        else
            hold_next = hold_reg + HOLD_WIDTH'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= '0;
        else if (advance)
            hold_reg <= hold_next;
    end

    assign hold = hold_reg;

endmodule

`default_nettype wire

@@ rtl/ubsr_core.sv @@
`default_nettype none

module ubsr_core
    import ubsr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic advance,
    input  wire logic down_pressed,
    input  wire logic up_pressed,
    input  wire logic cal_pressed,
    input  cfg_t      cfg,
    output result_t   result
);

    logic [HOLD_WIDTH-1:0]  down_hold;
    logic [HOLD_WIDTH-1:0]  up_hold;
    logic [HOLD_WIDTH-1:0]  cal_hold;
    logic [LEVEL_WIDTH-1:0] level_reg;
    logic [LEVEL_WIDTH-1:0] level_next;

    logic                   down_step;
    logic                   up_step;
    logic                   cal_req;
    logic [LEVEL_WIDTH:0]   cand;
    logic [LEVEL_WIDTH-1:0] floored;

    ubsr_hold_counter u_down_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (down_pressed),
        .hold    (down_hold)
    );

    ubsr_hold_counter u_up_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (up_pressed),
        .hold    (up_hold)
    );

    ubsr_hold_counter u_cal_hold (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pressed (cal_pressed),
        .hold    (cal_hold)
    );

    // Step decisions use the counts from before this tick
    always_comb
    begin
        down_step = down_pressed &&
            ((down_hold == '0) ||
             (CMP_WIDTH'(down_hold) > CMP_WIDTH'(cfg.repeat_after)));
        up_step = !down_step && up_pressed &&
            ((up_hold == '0) ||
             (CMP_WIDTH'(up_hold) > CMP_WIDTH'(cfg.repeat_after)));
        cal_req = !down_step && !up_step &&
            (CMP_WIDTH'(cal_hold) > CMP_WIDTH'(cfg.long_press_after));
    end

    // Step, floor at zero, then cap at setpoint_max
    always_comb
    begin
        if (down_step)
            cand = {1'b0, level_reg} - (LEVEL_WIDTH+1)'(cfg.step_size);
        else
            cand = {1'b0, level_reg} + (LEVEL_WIDTH+1)'(cfg.step_size);

        if (down_step && cand[LEVEL_WIDTH])
            floored = '0;
        else if (!down_step && cand[LEVEL_WIDTH])
            floored = cfg.setpoint_max;
        else
            floored = cand[LEVEL_WIDTH-1:0];

        if (down_step || up_step)
            level_next = (floored > cfg.setpoint_max) ? cfg.setpoint_max : floored;
        else
            level_next = level_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            level_reg <= '0;
        else if (advance)
            level_reg <= level_next;
    end

    assign result.setpoint_value    = level_next;
    assign result.updated           = down_step || up_step || cal_req;
    assign result.calibrate_request = cal_req;

endmodule

`default_nettype wire

@@ rtl/updown_button_setpoint_repeat.sv @@
// A tick passes the input register, then the result register, to the result port.
// Throughput: one tick per cycle. While a result waits, one more tick can sit in
// the input register; after that the input stalls until the result is taken.
// Reset (rst_n low, asynchronous): setpoint 0, hold counters 0, pipeline
// empty, registers back to step 4, max 254, repeat 13, long press 500.
`default_nettype none

module updown_button_setpoint_repeat
    import ubsr_pkg::*;
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // tick input
    input  wire logic                       in_valid,
    output logic                            in_stall,
    input  wire logic                       down_level,
    input  wire logic                       up_level,
    input  wire logic                       cal_level,
    // result output
    output logic                            out_valid,
    input  wire logic                       out_stall,
    output logic      [LEVEL_WIDTH-1:0]     setpoint_value,
    output logic                            updated,
    output logic                            calibrate_request,
    // configuration writes
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

    cfg_t    cfg;
    result_t result;

    logic    s1_valid_reg;
    logic    s1_down_reg;
    logic    s1_up_reg;
    logic    s1_cal_reg;
    logic    out_valid_reg;
    result_t out_reg;

    logic    out_free;
    logic    advance;
    logic    s1_load;

    assign cfg_ready = 1'b1;

    ubsr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Pipeline flow control
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign s1_load  = in_valid && !in_stall;

    // Input register: pressed flags (active-low levels)
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s1_load)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_down_reg <= !down_level;
            s1_up_reg   <= !up_level;
            s1_cal_reg  <= !cal_level;
        end
    end

    ubsr_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .down_pressed (s1_down_reg),
        .up_pressed   (s1_up_reg),
        .cal_pressed  (s1_cal_reg),
        .cfg          (cfg),
        .result       (result)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_reg <= result;
    end

    assign out_valid         = out_valid_reg;
    assign setpoint_value    = out_reg.setpoint_value;
    assign updated           = out_reg.updated;
    assign calibrate_request = out_reg.calibrate_request;

    // A request beat is always flagged as updated
    a_req_updated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_reg.calibrate_request || out_reg.updated))
        else $error("calibrate_request without updated");

    // Input stalls only when both stages are full and the output is held
    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && s1_valid_reg))
        else $error("input stalled with room in the pipeline");

    // A staged tick is never dropped without moving to the result register
    a_s1_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> s1_valid_reg)
        else $error("staged tick lost");

endmodule

`default_nettype wire

@@ bench/tb_updown_button_setpoint_repeat.sv @@
module tb_updown_button_setpoint_repeat;
    timeunit 1ns;
    timeprecision 1ps;

    import ubsr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam logic [HOLD_WIDTH-1:0] HOLD_TOP = '1;
    localparam int RANDOM_PHASES = 8;
    localparam int TICKS_PER_PHASE = 200;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       down_level = 1'b1;
    logic                       up_level = 1'b1;
    logic                       cal_level = 1'b1;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [LEVEL_WIDTH-1:0]     setpoint_value;
    logic                       updated;
    logic                       calibrate_request;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

    updown_button_setpoint_repeat dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .down_level        (down_level),
        .up_level          (up_level),
        .cal_level         (cal_level),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .setpoint_value    (setpoint_value),
        .updated           (updated),
        .calibrate_request (calibrate_request),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    always #5 clk = ~clk;

    // Setpoint model state and its copy of the registers
    logic [LEVEL_WIDTH-1:0] sp_level;
    logic [HOLD_WIDTH-1:0]  dn_hold;
    logic [HOLD_WIDTH-1:0]  up_hold;
    logic [HOLD_WIDTH-1:0]  cal_hold;
    logic [STEP_WIDTH-1:0]  cfg_step;
    logic [LEVEL_WIDTH-1:0] cfg_max;
    logic [RPT_WIDTH-1:0]   cfg_rpt;
    logic [LONG_WIDTH-1:0]  cfg_long;

    result_t expected_results[$];

    bit idle_on = 1'b1;
    int fail_count = 0;
    int checked_count = 0;
    int tick_count = 0;
    int write_count = 0;
    int cycle_count = 0;
    int sink_hold = 0;

    // Directed stimulus table
    typedef struct {
        bit         is_cfg;
        cfg_index_t idx;
        logic [CFG_DATA_WIDTH-1:0] data;
        logic       dn;
        logic       up;
        logic       cal;
        int         reps;
        bit         typed;
        result_t    res;
    } plan_row_t;

    plan_row_t plan[$];

    function automatic logic [HOLD_WIDTH-1:0] bump_hold(input logic [HOLD_WIDTH-1:0] h,
                                                        input logic pressed);
        if (!pressed)
            return '0;
        if (h == HOLD_TOP)
            return h;
        return h + 1'b1;
    endfunction

    function automatic logic [LEVEL_WIDTH-1:0] clamp_setpoint(input int v);
        if (v < 0)
            v = 0;
        if (v > int'(cfg_max))
            v = int'(cfg_max);
        return v[LEVEL_WIDTH-1:0];
    endfunction

    // One poll tick: decide on the old hold counts, then update them
    function automatic result_t predict_tick(input logic dn_lvl, input logic up_lvl,
                                             input logic cal_lvl);
        logic    dn;
        logic    up;
        logic    cal;
        result_t r;
        dn = !dn_lvl;
        up = !up_lvl;
        cal = !cal_lvl;
        r = '0;
        if (dn && (dn_hold == 0 || dn_hold > cfg_rpt))
        begin
            sp_level = clamp_setpoint(int'(sp_level) - int'(cfg_step));
            r.updated = 1'b1;
        end
        else if (up && (up_hold == 0 || up_hold > cfg_rpt))
        begin
            sp_level = clamp_setpoint(int'(sp_level) + int'(cfg_step));
            r.updated = 1'b1;
        end
        else if (cal_hold > cfg_long)
        begin
            r.calibrate_request = 1'b1;
            r.updated = 1'b1;
        end
        dn_hold = bump_hold(dn_hold, dn);
        up_hold = bump_hold(up_hold, up);
        cal_hold = bump_hold(cal_hold, cal);
        r.setpoint_value = sp_level;
        return r;
    endfunction

    function automatic void plan_tick(input logic dn, input logic up, input logic cal,
                                      input int reps);
        plan_row_t row;
        row = '{idx: REG_STEP_SIZE, default: '0};
        row.dn = dn;
        row.up = up;
        row.cal = cal;
        row.reps = reps;
        plan.push_back(row);
    endfunction

    function automatic void plan_tick_exp(input logic dn, input logic up, input logic cal,
                                          input logic [LEVEL_WIDTH-1:0] sp,
                                          input logic upd, input logic req);
        plan_row_t row;
        row = '{idx: REG_STEP_SIZE, default: '0};
        row.dn = dn;
        row.up = up;
        row.cal = cal;
        row.reps = 1;
        row.typed = 1'b1;
        row.res.setpoint_value = sp;
        row.res.updated = upd;
        row.res.calibrate_request = req;
        plan.push_back(row);
    endfunction

    function automatic void plan_cfg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        plan_row_t row;
        row = '{idx: REG_STEP_SIZE, default: '0};
        row.is_cfg = 1'b1;
        row.idx = idx;
        row.data = data;
        plan.push_back(row);
    endfunction

    // Drive one tick beat; valid stays high afterwards until the next call decides
    task automatic send_tick(input logic dn, input logic up, input logic cal,
                             input bit typed, input result_t typed_res);
        int      gap;
        result_t pred;
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        down_level <= dn;
        up_level <= up;
        cal_level <= cal;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pred = predict_tick(dn, up, cal);
        expected_results.push_back(typed ? typed_res : pred);
        tick_count++;
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_WIDTH-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_STEP_SIZE:        cfg_step = data[STEP_WIDTH-1:0];
            REG_SETPOINT_MAX:     cfg_max = data[LEVEL_WIDTH-1:0];
            REG_REPEAT_AFTER:     cfg_rpt = data[RPT_WIDTH-1:0];
            REG_LONG_PRESS_AFTER: cfg_long = data[LONG_WIDTH-1:0];
            default: ;
        endcase
        write_count++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure in bursts of random length
    always @(negedge clk)
    begin : sink_pace
        logic stall_next;
        if (sink_hold > 0)
        begin
            sink_hold--;
            stall_next = 1'b1;
        end
        else if (idle_on && $urandom_range(0, 3) == 0)
        begin
            sink_hold = $urandom_range(0, 3);
            stall_next = 1'b1;
        end
        else
            stall_next = 1'b0;
        out_stall <= stall_next;
    end

    // Compare each result beat with the oldest expectation
    always @(posedge clk)
    begin : result_check
        result_t got;
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.setpoint_value = setpoint_value;
            got.updated = updated;
            got.calibrate_request = calibrate_request;
            checked_count++;
            if (expected_results.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("ERROR: result beat with nothing expected: sp=%0d upd=%b req=%b",
                             got.setpoint_value, got.updated, got.calibrate_request);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.setpoint_value !== want.setpoint_value || got.updated !== want.updated
                    || got.calibrate_request !== want.calibrate_request)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("ERROR: beat %0d exp sp=%0d upd=%b req=%b got sp=%0d upd=%b req=%b",
                                 checked_count, want.setpoint_value, want.updated,
                                 want.calibrate_request, got.setpoint_value, got.updated,
                                 got.calibrate_request);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("ERROR: timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin : main_flow
        int         phase;
        int         made;
        int         len;
        int         run_cap;
        int         k;
        int         v;
        logic [2:0] btn;
        bit         saved_idle;
        result_t    none;

        none = '0;
        sp_level = '0;
        dn_hold = '0;
        up_hold = '0;
        cal_hold = '0;
        cfg_step = STEP_SIZE_RST;
        cfg_max = SETPOINT_MAX_RST;
        cfg_rpt = REPEAT_AFTER_RST;
        cfg_long = LONG_PRESS_AFTER_RST;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset values: step 4, max 254, repeat 13, long press 500
        plan_tick_exp(1, 1, 1, 0, 0, 0);
        plan_tick_exp(1, 0, 1, 4, 1, 0);
        plan_tick_exp(1, 0, 1, 4, 0, 0);
        plan_tick_exp(1, 1, 1, 4, 0, 0);
        // down wins over up
        plan_tick_exp(0, 0, 1, 0, 1, 0);
        // junk above the field widths is masked off
        plan_cfg(REG_STEP_SIZE, 16'hFFC0);
        plan_cfg(REG_SETPOINT_MAX, 16'hFFC8);
        plan_tick_exp(1, 1, 1, 0, 0, 0);
        // auto-repeat and clamp at the max
        plan_tick(1, 0, 1, 20);
        plan_tick_exp(1, 1, 1, 200, 0, 0);
        // max lowered under the level: kept until the next step
        plan_cfg(REG_SETPOINT_MAX, 16'h5500);
        plan_tick_exp(1, 1, 1, 200, 0, 0);
        plan_tick_exp(1, 0, 1, 0, 1, 0);
        plan_cfg(REG_SETPOINT_MAX, 16'h00FF);
        plan_cfg(REG_STEP_SIZE, 16'h0000);
        plan_tick_exp(1, 1, 1, 0, 0, 0);
        // zero step still flags an update
        plan_tick_exp(0, 1, 1, 0, 1, 0);
        plan_cfg(REG_STEP_SIZE, 16'h2A7F);
        plan_tick_exp(1, 1, 1, 0, 0, 0);
        plan_tick_exp(1, 0, 1, 127, 1, 0);
        plan_tick_exp(1, 1, 1, 127, 0, 0);
        plan_tick_exp(1, 0, 1, 254, 1, 0);
        plan_tick_exp(1, 1, 1, 254, 0, 0);
        plan_tick_exp(1, 0, 1, 255, 1, 0);
        // repeat threshold zero: every held tick steps
        plan_cfg(REG_REPEAT_AFTER, 16'hFC00);
        plan_tick(0, 1, 1, 4);
        plan_cfg(REG_REPEAT_AFTER, 16'h03FF);
        plan_cfg(REG_LONG_PRESS_AFTER, 16'h0000);
        plan_tick(1, 1, 0, 3);
        // a step suppresses the calibration request
        plan_tick(0, 1, 0, 2);
        // long press threshold near the top: a short hold never requests
        plan_cfg(REG_LONG_PRESS_AFTER, 16'hFFFE);
        plan_tick(1, 1, 1, 1);
        plan_tick(1, 1, 0, 40);
        plan_tick(1, 1, 1, 1);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                drain_results();
                write_reg(plan[i].idx, plan[i].data);
            end
            else
            begin
                saved_idle = idle_on;
                if (plan[i].reps > 50)
                    idle_on = 1'b0;
                repeat (plan[i].reps)
                    send_tick(plan[i].dn, plan[i].up, plan[i].cal, plan[i].typed, plan[i].res);
                idle_on = saved_idle;
            end
        end

        // Random phases, each with fresh register values
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            idle_on = !(phase == 3 || phase == RANDOM_PHASES - 1);
            drain_results();

            case ($urandom_range(0, 5))
                0:       v = 0;
                1:       v = 1;
                2:       v = 64;
                3:       v = 127;
                default: v = $urandom_range(1, 64);
            endcase
            write_reg(REG_STEP_SIZE, 16'(($urandom & 16'hFF80) | v[15:0]));
            case ($urandom_range(0, 3))
                0:       v = 0;
                1:       v = 255;
                default: v = $urandom_range(0, 255);
            endcase
            write_reg(REG_SETPOINT_MAX, 16'(($urandom & 16'hFF00) | v[15:0]));
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 1023;
                default: v = $urandom_range(0, 20);
            endcase
            write_reg(REG_REPEAT_AFTER, 16'(($urandom & 16'hFC00) | v[15:0]));
            case ($urandom_range(0, 7))
                0:       v = 0;
                1:       v = 65535;
                2:       v = $urandom_range(0, 65535);
                default: v = $urandom_range(0, 30);
            endcase
            write_reg(REG_LONG_PRESS_AFTER, v[15:0]);

            run_cap = (int'(cfg_rpt) > int'(cfg_long)) ? int'(cfg_rpt) : int'(cfg_long);
            run_cap = run_cap + 8;
            if (run_cap > 60)
                run_cap = 60;

            made = 0;
            while (made < TICKS_PER_PHASE)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    // held run of one or more buttons, then a release
                    k = $urandom_range(0, 9);
                    if (k < 3)
                        btn = 3'b011;
                    else if (k < 6)
                        btn = 3'b101;
                    else if (k < 8)
                        btn = 3'b110;
                    else
                        btn = 3'($urandom_range(0, 6));
                    len = $urandom_range(1, run_cap);
                    repeat (len)
                        send_tick(btn[2], btn[1], btn[0], 1'b0, none);
                    k = $urandom_range(1, 3);
                    repeat (k)
                        send_tick(1'b1, 1'b1, 1'b1, 1'b0, none);
                    made += len + k;
                end
                else
                begin
                    // noise: unrelated levels every tick
                    len = $urandom_range(1, 8);
                    repeat (len)
                    begin
                        btn = 3'($urandom);
                        send_tick(btn[2], btn[1], btn[0], 1'b0, none);
                    end
                    made += len;
                end
            end
        end

        drain_results();
        repeat (10) @(posedge clk);
        if (expected_results.size() != 0)
        begin
            fail_count += expected_results.size();
            $display("ERROR: %0d expected results never arrived", expected_results.size());
        end

        $display("Ran %0d ticks over %0d table rows and %0d random phases, %0d register writes",
                 tick_count, plan.size(), RANDOM_PHASES, write_count);
        $display("Compared %0d result beats, %0d failures", checked_count, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
